@@ rtl/core/cnw_pkg.sv @@
// Shared types, request codes and glyph tables for the character LCD nibble writer.
// Used by every module in rtl/core; depends on nothing.
package cnw_pkg;

	localparam logic [1:0] CMD_COMMAND = 2'd0;
	localparam logic [1:0] CMD_CHAR    = 2'd1;
	localparam logic [1:0] CMD_DECIMAL = 2'd2;

	localparam logic [2:0] DIGITS_ONE   = 3'd1;
	localparam logic [2:0] DIGITS_TWO   = 3'd2;
	localparam logic [2:0] DIGITS_THREE = 3'd3;
	localparam logic [2:0] DIGITS_FOUR  = 3'd4;

	localparam logic [7:0] CYR_FIRST = 8'd192;

	// reciprocal multipliers: floor(x / d) == (x * M) >> S over the stated range
	localparam logic [16:0] RECIP_1000 = 17'd67109;  // x < 2**16, S = 26
	localparam logic [16:0] RECIP_100  = 17'd83887;  // x < 2**16, S = 23
	localparam logic [15:0] RECIP_10   = 16'd52429;  // x < 2**16, S = 19
	localparam logic [7:0]  RECIP_B100 = 8'd164;     // x < 2**8,  S = 14
	localparam logic [7:0]  RECIP_B10  = 8'd205;     // x < 2**8,  S = 11

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] value;
		logic [2:0]  digit_count;
	} cnw_req_t;

	typedef struct packed {
		cnw_req_t    req;
		logic [6:0]  q1000;
		logic [9:0]  q100;
		logic [12:0] q10;
		logic [1:0]  bq100;
		logic [4:0]  bq10;
	} cnw_quot_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic            reg_select;
		logic [3:0]      nib_total;
	} cnw_pkt_t;

	function automatic logic [7:0] digit_glyph(input logic [3:0] d);
		logic [7:0] g;
		if (d < 4'd10) begin
			g = 8'h30 + {4'b0, d};
		end else begin
			g = 8'h37 + {4'b0, d};
		end
		return g;
	endfunction

	function automatic logic [7:0] cyr_glyph(input logic [5:0] i);
		logic [7:0] g;
		case (i)
			6'd0:  g = 8'h41;  6'd1:  g = 8'h80;  6'd2:  g = 8'h42;  6'd3:  g = 8'h81;
			6'd4:  g = 8'h82;  6'd5:  g = 8'h45;  6'd6:  g = 8'h83;  6'd7:  g = 8'h92;
			6'd8:  g = 8'h84;  6'd9:  g = 8'h85;  6'd10: g = 8'h4B;  6'd11: g = 8'h86;
			6'd12: g = 8'h4D;  6'd13: g = 8'h48;  6'd14: g = 8'h4F;  6'd15: g = 8'h87;
			6'd16: g = 8'h50;  6'd17: g = 8'h43;  6'd18: g = 8'h54;  6'd19: g = 8'h93;
			6'd20: g = 8'h88;  6'd21: g = 8'h58;  6'd22: g = 8'h89;  6'd23: g = 8'h8A;
			6'd24: g = 8'h8B;  6'd25: g = 8'h8C;  6'd26: g = 8'h8D;  6'd27: g = 8'h8E;
			6'd28: g = 8'h94;  6'd29: g = 8'h8F;  6'd30: g = 8'h90;  6'd31: g = 8'h91;
			6'd32: g = 8'h61;  6'd33: g = 8'hA0;  6'd34: g = 8'hB5;  6'd35: g = 8'hA1;
			6'd36: g = 8'hA2;  6'd37: g = 8'h65;  6'd38: g = 8'hA3;  6'd39: g = 8'hB2;
			6'd40: g = 8'hA4;  6'd41: g = 8'hA5;  6'd42: g = 8'hB6;  6'd43: g = 8'hA6;
			6'd44: g = 8'hB7;  6'd45: g = 8'hB8;  6'd46: g = 8'h6F;  6'd47: g = 8'hA7;
			6'd48: g = 8'h70;  6'd49: g = 8'h63;  6'd50: g = 8'hB9;  6'd51: g = 8'hB3;
			6'd52: g = 8'hA8;  6'd53: g = 8'h78;  6'd54: g = 8'hA9;  6'd55: g = 8'hAA;
			6'd56: g = 8'hAB;  6'd57: g = 8'hAC;  6'd58: g = 8'hAD;  6'd59: g = 8'hAE;
			6'd60: g = 8'hB4;  6'd61: g = 8'hAF;  6'd62: g = 8'hB0;  6'd63: g = 8'hB1;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

endpackage

@@ rtl/core/cnw_divide.sv @@
// Quotient stage: registers a request together with its decimal quotients.
// Depends on cnw_pkg.
module cnw_divide (
	input  logic                clk,
	input  logic                arst_n,
	input  cnw_pkg::cnw_req_t   req,
	input  logic                req_valid,
	output logic                req_ready,
	output cnw_pkg::cnw_quot_t  quot_s2,
	output logic                quot_valid,
	input  logic                quot_ready
);
	import cnw_pkg::*;

	logic        valid_s2;
	logic [33:0] p1000;
	logic [33:0] p100;
	logic [31:0] p10;
	logic [15:0] pb100;
	logic [15:0] pb10;
	cnw_quot_t   quot_d;

	assign p1000 = {18'b0, req.value} * {17'b0, RECIP_1000};
	assign p100  = {18'b0, req.value} * {17'b0, RECIP_100};
	assign p10   = {16'b0, req.value} * {16'b0, RECIP_10};
	assign pb100 = {8'b0, req.value[7:0]} * {8'b0, RECIP_B100};
	assign pb10  = {8'b0, req.value[7:0]} * {8'b0, RECIP_B10};

	always_comb begin
		quot_d.req   = req;
		quot_d.q1000 = p1000[32:26];
		quot_d.q100  = p100[32:23];
		quot_d.q10   = p10[31:19];
		quot_d.bq100 = pb100[15:14];
		quot_d.bq10  = pb10[15:11];
	end

	assign req_ready  = !valid_s2 || quot_ready;
	assign quot_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (req_ready) begin
			valid_s2 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			quot_s2 <= quot_d;
		end
	end

endmodule

@@ rtl/core/cnw_format.sv @@
// Byte formatter: turns a request and its quotients into up to four bytes and a nibble count.
// Depends on cnw_pkg.
module cnw_format (
	input  cnw_pkg::cnw_quot_t quot,
	output cnw_pkg::cnw_pkt_t  pkt
);
	import cnw_pkg::*;

	logic [9:0]  d1;
	logic [12:0] d2;
	logic [15:0] d3;
	logic [4:0]  e0;
	logic [7:0]  e1;
	logic [7:0]  chr;

	assign d1 = quot.q100 - {quot.q1000, 3'b0} - {2'b0, quot.q1000, 1'b0};
	assign d2 = quot.q10 - {quot.q100, 3'b0} - {2'b0, quot.q100, 1'b0};
	assign d3 = quot.req.value - {quot.q10, 3'b0} - {2'b0, quot.q10, 1'b0};
	assign e0 = quot.bq10 - {quot.bq100, 3'b0} - {2'b0, quot.bq100, 1'b0};
	assign e1 = quot.req.value[7:0] - {quot.bq10, 3'b0} - {2'b0, quot.bq10, 1'b0};

	assign chr = (quot.req.value[7:0] >= CYR_FIRST) ? cyr_glyph(quot.req.value[5:0])
	                                                : quot.req.value[7:0];

	always_comb begin
		pkt.bytes      = '0;
		pkt.reg_select = 1'b1;
		pkt.nib_total  = 4'd0;
		case (quot.req.cmd)
			CMD_COMMAND: begin
				pkt.bytes[0]   = quot.req.value[7:0];
				pkt.reg_select = 1'b0;
				pkt.nib_total  = 4'd2;
			end
			CMD_CHAR: begin
				pkt.bytes[0]  = chr;
				pkt.nib_total = 4'd2;
			end
			CMD_DECIMAL: begin
				case (quot.req.digit_count)
					DIGITS_FOUR: begin
						pkt.bytes[0]  = digit_glyph(quot.q1000[3:0]);
						pkt.bytes[1]  = digit_glyph(d1[3:0]);
						pkt.bytes[2]  = digit_glyph(d2[3:0]);
						pkt.bytes[3]  = digit_glyph(d3[3:0]);
						pkt.nib_total = 4'd8;
					end
					DIGITS_THREE: begin
						pkt.bytes[0]  = digit_glyph(quot.q100[3:0]);
						pkt.bytes[1]  = digit_glyph(d2[3:0]);
						pkt.bytes[2]  = digit_glyph(d3[3:0]);
						pkt.nib_total = 4'd6;
					end
					DIGITS_TWO: begin
						pkt.bytes[0]  = digit_glyph(e0[3:0]);
						pkt.bytes[1]  = digit_glyph(e1[3:0]);
						pkt.nib_total = 4'd4;
					end
					DIGITS_ONE: begin
						pkt.bytes[0]  = digit_glyph(quot.req.value[3:0]);
						pkt.nib_total = 4'd2;
					end
					default: begin
						pkt.nib_total = 4'd0;
					end
				endcase
			end
			default: begin
				pkt.nib_total = 4'd0;
			end
		endcase
	end

endmodule

@@ rtl/core/cnw_serial.sv @@
// Nibble serializer: holds one formatted request and sends it one nibble per cycle.
// A nibble waits while m_tready is low. Depends on cnw_pkg.
module cnw_serial (
	input  logic              clk,
	input  logic              arst_n,
	input  cnw_pkg::cnw_pkt_t pkt,
	input  logic              pkt_valid,
	output logic              pkt_ready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);
	import cnw_pkg::*;

	logic       busy_q;
	logic [2:0] idx_q;
	cnw_pkt_t   buf_q;
	logic [7:0] cur_byte;
	logic       last;

	assign cur_byte = buf_q.bytes[idx_q[2:1]];
	assign last     = ({1'b0, idx_q} + 4'd1) == buf_q.nib_total;

	assign m_tvalid  = busy_q;
	assign m_tdata   = {4'b0, idx_q[0] ? cur_byte[3:0] : cur_byte[7:4]};
	assign m_tuser   = buf_q.reg_select;
	assign m_tlast   = last;
	assign pkt_ready = !busy_q || (m_tready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pkt_ready) begin
			busy_q <= pkt_valid && (pkt.nib_total != 4'd0);
			idx_q  <= '0;
		end else if (m_tready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_ready && pkt_valid) begin
			buf_q <= pkt;
		end
	end

endmodule

@@ rtl/core/char_lcd_nibble_writer.sv @@
// Top level of the character LCD nibble writer: input register, quotient stage,
// formatter and nibble serializer. Depends on cnw_pkg, cnw_divide, cnw_format, cnw_serial.
//
// Use:
// - s_* carries requests: tuser = kind (command byte, character, decimal number),
//   tdata = value and digit count. Each request becomes a run of 4-bit transfers.
// - m_* carries nibble transfers: tdata[3:0] = bus bits DB7..DB4, tuser = register
//   select, tlast = final nibble of the request. High nibble goes first.
// - Path: a request passes the input register, the quotient stage register and the
//   serializer buffer before its first nibble is offered.
// - Throughput: one nibble per cycle while m_tready is high; a request sends two nibbles
//   per byte of its formatted output. The serializer sets the rate; the front stages hold
//   up to two waiting requests while it drains.
// - Requests of unknown kind or bad digit count pass through and send nothing.
// - When the receiver stalls, the current nibble holds and the front stages fill and
//   then drop s_tready.
// - Reset empties every stage; nothing is sent until a new request arrives.
module char_lcd_nibble_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] value, [18:16] digit_count, [23:19] zero
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [3:0] nibble, [7:4] zero
	output logic        m_tuser,   // [0] reg_select
	output logic        m_tlast
);
	import cnw_pkg::*;

	cnw_req_t  req_s1;
	logic      valid_s1;
	logic      ready_s2;
	cnw_quot_t quot_s2;
	logic      valid_s2;
	logic      ready_s3;
	cnw_pkt_t  pkt;

	assign s_tready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.cmd         <= s_tuser;
			req_s1.value       <= s_tdata[15:0];
			req_s1.digit_count <= s_tdata[18:16];
		end
	end

	cnw_divide u_divide (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_s1),
		.req_valid  (valid_s1),
		.req_ready  (ready_s2),
		.quot_s2    (quot_s2),
		.quot_valid (valid_s2),
		.quot_ready (ready_s3)
	);

	cnw_format u_format (
		.quot (quot_s2),
		.pkt  (pkt)
	);

	cnw_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt),
		.pkt_valid (valid_s2),
		.pkt_ready (ready_s3),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

`ifndef SYNTHESIS
	a_cmd_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tuser && !m_tlast |=> m_tvalid && m_tlast && !m_tuser)
		else $error("command byte not sent as two nibbles");

	a_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(req_s1))
		else $error("stalled request lost or changed");
`endif

endmodule

@@ tb/sv/char_lcd_nibble_writer_test.sv @@
// Testbench for char_lcd_nibble_writer: drives command, character and decimal requests
// and checks every nibble transfer against an in-bench prediction of the bus sequence.
// Depends on cnw_pkg and the char_lcd_nibble_writer RTL.
`timescale 1ns / 100ps

module char_lcd_nibble_writer_test;
	import cnw_pkg::*;

	localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
	localparam logic [2:0] DIGITS_NONE  = 3'd0;
	localparam logic [2:0] DIGITS_FIVE  = 3'd5;
	localparam logic [2:0] DIGITS_SEVEN = 3'd7;
	localparam int         STALL_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [3:0] nibble;
		logic       reg_select;
		logic       last;
	} lcd_xfer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	lcd_xfer_t   pending_xfers[$];
	lcd_xfer_t   want;
	int          mismatch_count = 0;
	int          stall_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	string       digit_chars = "0123456789ABCDEF";

	logic [7:0] cyr_map [0:63] = '{
		8'h41, 8'h80, 8'h42, 8'h81, 8'h82, 8'h45, 8'h83, 8'h92,
		8'h84, 8'h85, 8'h4B, 8'h86, 8'h4D, 8'h48, 8'h4F, 8'h87,
		8'h50, 8'h43, 8'h54, 8'h93, 8'h88, 8'h58, 8'h89, 8'h8A,
		8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h94, 8'h8F, 8'h90, 8'h91,
		8'h61, 8'hA0, 8'hB5, 8'hA1, 8'hA2, 8'h65, 8'hA3, 8'hB2,
		8'hA4, 8'hA5, 8'hB6, 8'hA6, 8'hB7, 8'hB8, 8'h6F, 8'hA7,
		8'h70, 8'h63, 8'hB9, 8'hB3, 8'hA8, 8'h78, 8'hA9, 8'hAA,
		8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hB4, 8'hAF, 8'hB0, 8'hB1
	};

	char_lcd_nibble_writer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int exp);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, exp);
		mismatch_count++;
	endtask

	// expected bus transfers for one request, high nibble of each byte first
	function automatic void predict_xfers(input logic [1:0] cmd, input logic [15:0] value,
			input logic [2:0] count);
		logic [7:0] chars[$];
		logic       rs;
		lcd_xfer_t  x;
		int         v;
		int         b;
		v = int'(value);
		b = int'(value[7:0]);
		rs = 1'b1;
		if (cmd == CMD_COMMAND) begin
			chars.push_back(value[7:0]);
			rs = 1'b0;
		end else if (cmd == CMD_CHAR) begin
			if (value[7:0] >= CYR_FIRST) begin
				chars.push_back(cyr_map[value[5:0]]);
			end else begin
				chars.push_back(value[7:0]);
			end
		end else if (cmd == CMD_DECIMAL) begin
			case (count)
				DIGITS_FOUR: begin
					chars.push_back(digit_chars[(v / 1000) % 16]);
					chars.push_back(digit_chars[((v % 1000) / 100) % 16]);
					chars.push_back(digit_chars[(v % 100) / 10]);
					chars.push_back(digit_chars[v % 10]);
				end
				DIGITS_THREE: begin
					chars.push_back(digit_chars[(v / 100) % 16]);
					chars.push_back(digit_chars[(v % 100) / 10]);
					chars.push_back(digit_chars[v % 10]);
				end
				DIGITS_TWO: begin
					chars.push_back(digit_chars[(b % 100) / 10]);
					chars.push_back(digit_chars[b % 10]);
				end
				DIGITS_ONE: begin
					chars.push_back(digit_chars[value[3:0]]);
				end
				default: ;
			endcase
		end
		foreach (chars[i]) begin
			x.reg_select = rs;
			x.last = 1'b0;
			x.nibble = chars[i][7:4];
			pending_xfers.push_back(x);
			x.nibble = chars[i][3:0];
			x.last = (i == chars.size() - 1);
			pending_xfers.push_back(x);
		end
	endfunction

	task automatic send_request(input logic [1:0] cmd, input logic [15:0] value,
			input logic [2:0] count);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {5'b0, count, value};
		do @(posedge clk); while (!s_tready);
		predict_xfers(cmd, value, count);
	endtask

	task automatic test_command_bytes;
		send_request(CMD_COMMAND, 16'h0000, DIGITS_NONE);
		send_request(CMD_COMMAND, 16'hFFFF, DIGITS_SEVEN);
		send_request(CMD_COMMAND, 16'h5A28, DIGITS_ONE);
	endtask

	task automatic test_characters;
		send_request(CMD_CHAR, 16'h0000, DIGITS_NONE);
		send_request(CMD_CHAR, 16'h007F, DIGITS_FOUR);
		send_request(CMD_CHAR, 16'hAABF, DIGITS_TWO);
		send_request(CMD_CHAR, 16'h00C0, DIGITS_NONE);
		send_request(CMD_CHAR, 16'h00E0, DIGITS_THREE);
		send_request(CMD_CHAR, 16'hFFFF, DIGITS_SEVEN);
	endtask

	task automatic test_decimals;
		send_request(CMD_DECIMAL, 16'd0, DIGITS_FOUR);
		send_request(CMD_DECIMAL, 16'd9999, DIGITS_FOUR);
		send_request(CMD_DECIMAL, 16'd65535, DIGITS_FOUR);
		send_request(CMD_DECIMAL, 16'd999, DIGITS_THREE);
		send_request(CMD_DECIMAL, 16'd65535, DIGITS_THREE);
		send_request(CMD_DECIMAL, 16'd255, DIGITS_TWO);
		send_request(CMD_DECIMAL, 16'd1099, DIGITS_TWO);
		send_request(CMD_DECIMAL, 16'd0, DIGITS_ONE);
		send_request(CMD_DECIMAL, 16'hFFFF, DIGITS_ONE);
		send_request(CMD_DECIMAL, 16'h000A, DIGITS_ONE);
	endtask

	task automatic test_ignored_requests;
		send_request(CMD_UNKNOWN, 16'hFFFF, DIGITS_FOUR);
		send_request(CMD_DECIMAL, 16'd1234, DIGITS_NONE);
		send_request(CMD_DECIMAL, 16'd1234, DIGITS_FIVE);
		send_request(CMD_DECIMAL, 16'hFFFF, DIGITS_SEVEN);
		send_request(CMD_COMMAND, 16'h0081, DIGITS_ONE);
	endtask

	task automatic test_random_traffic(input int count);
		int          sent;
		int          roll;
		logic [15:0] value;
		logic [2:0]  digits;
		logic [1:0]  cmd;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(0, 99);
			value = 16'($urandom);
			if ($urandom_range(0, 3) == 0) begin
				value = 16'($urandom_range(0, 1099));
			end
			digits = 3'($urandom);
			if (roll < 20) begin
				cmd = CMD_COMMAND;
			end else if (roll < 50) begin
				cmd = CMD_CHAR;
				if ($urandom_range(0, 1) == 0) begin
					value[7:0] = 8'($urandom_range(CYR_FIRST, 255));
				end
			end else if (roll < 90) begin
				cmd = CMD_DECIMAL;
				digits = 3'($urandom_range(DIGITS_ONE, DIGITS_FOUR));
			end else if (roll < 95) begin
				cmd = CMD_UNKNOWN;
			end else begin
				cmd = CMD_DECIMAL;
				digits = ($urandom_range(0, 3) == 0) ? DIGITS_NONE
					: 3'($urandom_range(DIGITS_FIVE, DIGITS_SEVEN));
			end
			send_request(cmd, value, digits);
			sent++;
		end
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_xfers.size() == 0) begin
				report_mismatch("unexpected transfer, nibble", m_tdata[3:0], 0);
			end else begin
				want = pending_xfers.pop_front();
				if (m_tdata[3:0] !== want.nibble) begin
					report_mismatch("nibble", m_tdata[3:0], want.nibble);
				end
				if (m_tuser !== want.reg_select) begin
					report_mismatch("reg_select", m_tuser, want.reg_select);
				end
				if (m_tlast !== want.last) begin
					report_mismatch("last", m_tlast, want.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 30;
		recv_idle_pct = 61;
		test_command_bytes();
		test_characters();
		test_decimals();
		test_ignored_requests();
		test_random_traffic(160);

		send_idle_pct = 61;
		recv_idle_pct = 30;
		test_random_traffic(160);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(160);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_xfers.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
